### src/wpm_pkg.sv
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared constants, types and helpers for the wildcard pattern matcher.
// ----------------------------------------------------------------------------
package wpm_pkg;

	// pattern capacity and derived widths
	localparam int MAX_PATTERN = 32;
	localparam int ADDR_W      = $clog2(MAX_PATTERN);
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

	// special pattern bytes
	localparam logic [7:0] STAR_BYTE = 8'h2A;
	localparam logic [7:0] DOT_BYTE  = 8'h2E;

	// request opcodes
	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_BEGIN  = 2'd2,
		OP_TEXT   = 2'd3
	} op_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SWEEP,
		ST_DONE
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic start;
		logic fetch;
		logic sweep;
		logic load_out;
	} ctl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic last_col;
		logic len_zero;
	} ctl_sts_t;

	// pattern element accepts a text byte
	function automatic logic elem_accepts(input logic [7:0] pat, input logic [7:0] c);
		elem_accepts = (pat == DOT_BYTE) || (pat == c);
	endfunction

endpackage

### src/wpm_ram.sv
// ----------------------------------------------------------------------------
// wpm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/wpm_ctrl.sv
// ----------------------------------------------------------------------------
// wpm_ctrl
// Controller: request handshake, column sweep sequencing, output register valid.
// ----------------------------------------------------------------------------
module wpm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	input  wpm_pkg::ctl_sts_t   sts,
	output wpm_pkg::ctl_cmd_t   cmd
);

	wpm_pkg::state_t state_q, state_d;
	logic            out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wpm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		s_axis_tready = 1'b0;
		unique case (state_q)
			wpm_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.start = 1'b1;
					state_d   = wpm_pkg::ST_FETCH;
				end
			end
			wpm_pkg::ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = sts.len_zero ? wpm_pkg::ST_DONE : wpm_pkg::ST_SWEEP;
			end
			wpm_pkg::ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.last_col) begin
					state_d = wpm_pkg::ST_DONE;
				end
			end
			wpm_pkg::ST_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					cmd.load_out = 1'b1;
					state_d      = wpm_pkg::ST_IDLE;
				end
			end
			default: state_d = wpm_pkg::ST_IDLE;
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;

endmodule

### src/wpm_dpath.sv
// ----------------------------------------------------------------------------
// wpm_dpath
// Datapath: pattern RAM, length, match row updated one column per cycle.
// ----------------------------------------------------------------------------
module wpm_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  wpm_pkg::ctl_cmd_t cmd,
	output wpm_pkg::ctl_sts_t sts,
	input  logic [1:0]        op,
	input  logic [7:0]        symbol,
	output logic              matched,
	output logic              overflow
);

	logic [wpm_pkg::LEN_W-1:0]   len_q;
	logic [wpm_pkg::MAX_PATTERN:0] row_q;
	logic [wpm_pkg::LEN_W-1:0]   j_q;
	logic                        text_q;
	logic [7:0]                  sym_q;
	logic                        ovf_q;
	logic                        old_prev_q;
	logic [7:0]                  prev_pat_q;

	logic                        has_room;
	logic                        ram_we;
	logic [wpm_pkg::ADDR_W-1:0]  ram_raddr;
	logic [7:0]                  pat;
	logic [wpm_pkg::LEN_W-1:0]   jm1;
	logic [wpm_pkg::LEN_W-1:0]   jm2;
	logic                        j_gt1;
	logic                        new_bit;

	assign has_room = (len_q < wpm_pkg::LEN_W'(wpm_pkg::MAX_PATTERN));
	assign ram_we   = cmd.start && (wpm_pkg::op_t'(op) == wpm_pkg::OP_APPEND) && has_room;
	assign jm1      = j_q - wpm_pkg::LEN_W'(1);
	assign j_gt1    = (j_q > wpm_pkg::LEN_W'(1));
	assign jm2      = j_gt1 ? (j_q - wpm_pkg::LEN_W'(2)) : '0;

	// fetch reads pattern byte j-1, sweep reads ahead for the next column
	assign ram_raddr = cmd.fetch ? jm1[wpm_pkg::ADDR_W-1:0] : j_q[wpm_pkg::ADDR_W-1:0];

	wpm_ram #(
		.WIDTH(8),
		.DEPTH(wpm_pkg::MAX_PATTERN)
	) u_pat_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(len_q[wpm_pkg::ADDR_W-1:0]),
		.wdata(symbol),
		.raddr(ram_raddr),
		.rdata(pat)
	);

	// next value of column j
	always_comb begin
		if (!text_q) begin
			new_bit = j_gt1 && (pat == wpm_pkg::STAR_BYTE) && row_q[jm2];
		end else if (pat != wpm_pkg::STAR_BYTE) begin
			new_bit = old_prev_q && wpm_pkg::elem_accepts(pat, sym_q);
		end else begin
			new_bit = j_gt1 && (row_q[jm2] ||
				(row_q[j_q] && wpm_pkg::elem_accepts(prev_pat_q, sym_q)));
		end
	end

	// pattern length and row control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			row_q  <= {{wpm_pkg::MAX_PATTERN{1'b0}}, 1'b1};
			j_q    <= '0;
			text_q <= 1'b0;
			ovf_q  <= 1'b0;
		end else if (cmd.start) begin
			j_q    <= wpm_pkg::LEN_W'(1);
			ovf_q  <= 1'b0;
			text_q <= (wpm_pkg::op_t'(op) == wpm_pkg::OP_TEXT);
			unique case (wpm_pkg::op_t'(op))
				wpm_pkg::OP_CLEAR: begin
					len_q <= '0;
					row_q <= {{wpm_pkg::MAX_PATTERN{1'b0}}, 1'b1};
				end
				wpm_pkg::OP_APPEND: begin
					if (has_room) begin
						len_q <= len_q + wpm_pkg::LEN_W'(1);
					end else begin
						ovf_q <= 1'b1;
					end
					row_q <= {{wpm_pkg::MAX_PATTERN{1'b0}}, 1'b1};
				end
				wpm_pkg::OP_BEGIN: begin
					row_q <= {{wpm_pkg::MAX_PATTERN{1'b0}}, 1'b1};
				end
				wpm_pkg::OP_TEXT: begin
					row_q[0] <= 1'b0;
				end
				default: row_q <= row_q;
			endcase
		end else if (cmd.sweep) begin
			row_q[j_q] <= new_bit;
			j_q        <= j_q + wpm_pkg::LEN_W'(1);
		end
	end

	// payload registers of the sweep
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sym_q      <= symbol;
			old_prev_q <= row_q[0];
		end else if (cmd.sweep) begin
			old_prev_q <= row_q[j_q];
			prev_pat_q <= pat;
		end
	end

	// output data register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			matched  <= row_q[len_q];
			overflow <= ovf_q;
		end
	end

	assign sts.last_col = (j_q == len_q);
	assign sts.len_zero = (len_q == '0);

endmodule

### src/wildcard_pattern_matcher_top.sv
// A request is accepted only in the idle state; the controller then fetches,
// sweeps the match row one column per cycle through the single pattern RAM
// read port, and loads the output register before it accepts the next request.
// A finished result waits in the output register while the next request runs.
// Reset: empty pattern, match row at row zero, no result pending;
// the pattern RAM keeps its contents and is not cleared.
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_top
// Full-text match against a stored pattern with '.' and '*' wildcards.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] symbol
	input  logic [1:0] s_axis_tuser,   // [1:0] op
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata    // [0] matched, [1] overflow, [7:2] zero
);

	wpm_pkg::ctl_cmd_t cmd;
	wpm_pkg::ctl_sts_t sts;
	logic              matched;
	logic              overflow;

	// controller
	wpm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.sts          (sts),
		.cmd          (cmd)
	);

	// datapath
	wpm_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.op      (s_axis_tuser),
		.symbol  (s_axis_tdata),
		.matched (matched),
		.overflow(overflow)
	);

	assign m_axis_tdata = {6'b0, overflow, matched};

endmodule
